// ===== design/apsp_pkg.sv =====
// ----------------------------------------------------------------------------
// apsp_pkg: shared constants and helpers for the shortest path block
// Sizes of the distance and via stores, field widths, function codes and the
// cell address helper.
// ----------------------------------------------------------------------------
package apsp_pkg;

  // Store geometry.
  localparam int MAX_VERTICES = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int CELLS        = MAX_VERTICES * MAX_VERTICES;
  localparam int ADDR_W       = $clog2(CELLS);

  // Field widths fixed by the interface.
  localparam int VTX_W  = 4;
  localparam int DIST_W = 17;
  localparam int VC_W   = 5;

  // The distance that stands for no edge; also the saturation limit of sums.
  localparam logic [DIST_W-1:0] NO_EDGE = DIST_W'(99999);

  // Reset value of the vertex count register.
  localparam logic [VC_W-1:0] VC_RESET = VC_W'(16);

  // Function codes of a request.
  typedef enum logic [1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_COMPUTE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  // Address of the cell for a row and a column vertex.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [IDX_W-1:0] row,
                                                 input logic [IDX_W-1:0] col);
    cell_addr = ADDR_W'(row) * ADDR_W'(MAX_VERTICES) + ADDR_W'(col);
  endfunction

endpackage

// ===== design/all_pairs_shortest_path_via_unit.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_via_unit: all-pairs shortest paths with via vertex
// Loads edge weights, runs the relaxation over every triple of vertices in use
// with one shared adder and comparator, and answers reads of one vertex pair.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in_ channel: in_tuser carries the function (load,
//   compute, read), in_tdata the row vertex, column vertex and edge weight.
//   Every request yields exactly one result on the out_ channel. The user must write
//   the vertex count via cfg_wr_en / cfg_wr_data while idle; this is not enforced.
// Sequence:
//   A load or an unused function code passes S_POST into the output register;
//   a read passes S_RWAIT and S_POST. in_tready is high only while the
//   sequencer is idle, so no new request is taken until the last result has
//   left S_POST. A compute writes the diagonal entries of the n vertices in
//   use (S_DIAG); then each row of each pass fetches the pivot column entry
//   (S_RIK, S_LIK) and each triple reads two distance copies (S_RD), then
//   does the saturating add, compare and write back (S_UPD).
// Reset:
//   The vertex count returns to 16 and all via entries read as none; the
//   distance store is undefined until loaded.
// Stall:
//   A result waits in the output register while out_tready is low; the
//   block still accepts the next request and holds its result until the
//   output register is free.
// ----------------------------------------------------------------------------
module all_pairs_shortest_path_via_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: vertex_count.
  input  logic        cfg_wr_en,
  input  logic [4:0]  cfg_wr_data,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // row_vertex[3:0], col_vertex[7:4], edge_weight[24:8]
  input  logic [1:0]  in_tuser,   // func[1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // distance[16:0], via_vertex[20:17], has_via[21],
                                  // done_res[22]
);

  localparam int IDX_W  = apsp_pkg::IDX_W;
  localparam int ADDR_W = apsp_pkg::ADDR_W;
  localparam int DIST_W = apsp_pkg::DIST_W;
  localparam int VTX_W  = apsp_pkg::VTX_W;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RWAIT,
    S_DIAG,
    S_RIK,
    S_LIK,
    S_RD,
    S_UPD,
    S_POST
  } state_t;

  state_t state_r;

  // Request fields.
  logic [VTX_W-1:0]  in_row;
  logic [VTX_W-1:0]  in_col;
  logic [DIST_W-1:0] in_weight;
  apsp_pkg::func_t   in_func;
  logic              in_acc;
  logic              in_store;
  logic [ADDR_W-1:0] in_cell;
  logic [DIST_W-1:0] in_weight_sat;

  assign in_row    = in_tdata[3:0];
  assign in_col    = in_tdata[7:4];
  assign in_weight = in_tdata[24:8];
  assign in_func   = apsp_pkg::func_t'(in_tuser);
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_store  = (32'(in_row) < apsp_pkg::MAX_VERTICES) &&
                     (32'(in_col) < apsp_pkg::MAX_VERTICES);
  assign in_cell   = apsp_pkg::cell_addr(IDX_W'(in_row), IDX_W'(in_col));
  assign in_weight_sat = (in_weight > apsp_pkg::NO_EDGE) ? apsp_pkg::NO_EDGE : in_weight;

  // Registers.
  logic [apsp_pkg::VC_W-1:0] vertex_count_r;
  logic [IDX_W-1:0]          last_r;
  logic [IDX_W-1:0]          i_r;
  logic [IDX_W-1:0]          j_r;
  logic [IDX_W-1:0]          k_r;
  logic [DIST_W-1:0]         dik_r;
  logic [apsp_pkg::CELLS-1:0] via_valid_r;
  logic                      rd_in_store_r;
  logic                      rd_via_ok_r;
  logic [DIST_W-1:0]         res_dist_r;
  logic [VTX_W-1:0]          res_via_r;
  logic                      res_has_r;
  logic                      res_done_r;
  logic                      out_valid_r;
  logic [DIST_W-1:0]         out_dist_r;
  logic [VTX_W-1:0]          out_via_r;
  logic                      out_has_r;
  logic                      out_done_r;

  // Memory ports.
  logic              dist_wr_en;
  logic [ADDR_W-1:0] dist_wr_addr;
  logic [DIST_W-1:0] dist_wr_data;
  logic [ADDR_W-1:0] rd_addr_a;
  logic [ADDR_W-1:0] rd_addr_b;
  logic [DIST_W-1:0] rd_data_a;
  logic [DIST_W-1:0] rd_data_b;
  logic              via_wr_en;
  logic [IDX_W-1:0]  via_rd_data;

  // Clamped last vertex index from the vertex count register.
  logic [IDX_W-1:0] last_nxt;

  always_comb begin
    priority if (vertex_count_r == '0) begin
      last_nxt = '0;
    end else if (32'(vertex_count_r) > apsp_pkg::MAX_VERTICES) begin
      last_nxt = IDX_W'(apsp_pkg::MAX_VERTICES - 1);
    end else begin
      last_nxt = IDX_W'(vertex_count_r - apsp_pkg::VC_W'(1));
    end
  end

  // Shared unit: saturating add of the two path halves and the strict compare.
  logic [DIST_W:0]   sum_full;
  logic [DIST_W-1:0] sum_sat;
  logic              improve;

  assign sum_full = {1'b0, dik_r} + {1'b0, rd_data_a};
  assign sum_sat  = (sum_full > {1'b0, apsp_pkg::NO_EDGE}) ? apsp_pkg::NO_EDGE
                                                          : sum_full[DIST_W-1:0];
  assign improve  = (rd_data_b > sum_sat);

  // Memory port control per sequencer state.
  always_comb begin
    dist_wr_en   = 1'b0;
    dist_wr_addr = in_cell;
    dist_wr_data = in_weight_sat;
    rd_addr_a    = in_cell;
    rd_addr_b    = in_cell;
    via_wr_en    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        dist_wr_en = in_acc && (in_func == apsp_pkg::FUNC_LOAD) && in_store;
      end
      S_DIAG: begin
        dist_wr_en   = 1'b1;
        dist_wr_addr = apsp_pkg::cell_addr(i_r, i_r);
        dist_wr_data = '0;
      end
      S_RIK: begin
        rd_addr_a = apsp_pkg::cell_addr(i_r, k_r);
      end
      S_RD: begin
        rd_addr_a = apsp_pkg::cell_addr(k_r, j_r);
        rd_addr_b = apsp_pkg::cell_addr(i_r, j_r);
      end
      S_UPD: begin
        dist_wr_en   = improve;
        dist_wr_addr = apsp_pkg::cell_addr(i_r, j_r);
        dist_wr_data = sum_sat;
        via_wr_en    = improve;
      end
      default: begin
      end
    endcase
  end

  // Two identical copies of the distance store give two reads per cycle.
  apsp_ram #(.WIDTH(DIST_W), .DEPTH(apsp_pkg::CELLS)) u_dist_a (
    .clk     (clk),
    .wr_en   (dist_wr_en),
    .wr_addr (dist_wr_addr),
    .wr_data (dist_wr_data),
    .rd_addr (rd_addr_a),
    .rd_data (rd_data_a)
  );

  apsp_ram #(.WIDTH(DIST_W), .DEPTH(apsp_pkg::CELLS)) u_dist_b (
    .clk     (clk),
    .wr_en   (dist_wr_en),
    .wr_addr (dist_wr_addr),
    .wr_data (dist_wr_data),
    .rd_addr (rd_addr_b),
    .rd_data (rd_data_b)
  );

  // Via vertex store; its valid bits live in flip-flops.
  apsp_ram #(.WIDTH(IDX_W), .DEPTH(apsp_pkg::CELLS)) u_via (
    .clk     (clk),
    .wr_en   (via_wr_en),
    .wr_addr (dist_wr_addr),
    .wr_data (k_r),
    .rd_addr (in_cell),
    .rd_data (via_rd_data)
  );

  // A finished result moves into the output register once it is free.
  logic post_fire;

  assign post_fire = (state_r == S_POST) && (!out_valid_r || out_tready);

  // Sequencer, configuration register and result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      vertex_count_r <= apsp_pkg::VC_RESET;
      via_valid_r    <= '0;
      out_valid_r    <= 1'b0;
      i_r            <= '0;
      j_r            <= '0;
      k_r            <= '0;
      last_r         <= '0;
    end else begin
      if (cfg_wr_en) begin
        vertex_count_r <= cfg_wr_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            res_dist_r <= '0;
            res_via_r  <= '0;
            res_has_r  <= 1'b0;
            res_done_r <= (in_func != apsp_pkg::FUNC_NONE);
            unique case (in_func)
              apsp_pkg::FUNC_LOAD: begin
                state_r <= S_POST;
              end
              apsp_pkg::FUNC_COMPUTE: begin
                via_valid_r <= '0;
                last_r      <= last_nxt;
                i_r         <= '0;
                state_r     <= S_DIAG;
              end
              apsp_pkg::FUNC_READ: begin
                rd_in_store_r <= in_store;
                rd_via_ok_r   <= in_store && via_valid_r[in_cell];
                state_r       <= S_RWAIT;
              end
              default: begin
                state_r <= S_POST;
              end
            endcase
          end
        end
        S_RWAIT: begin
          res_dist_r <= rd_in_store_r ? rd_data_a : apsp_pkg::NO_EDGE;
          res_via_r  <= rd_via_ok_r ? VTX_W'(via_rd_data) : '0;
          res_has_r  <= rd_via_ok_r;
          state_r    <= S_POST;
        end
        S_DIAG: begin
          if (i_r == last_r) begin
            i_r     <= '0;
            j_r     <= '0;
            k_r     <= '0;
            state_r <= S_RIK;
          end else begin
            i_r <= i_r + IDX_W'(1);
          end
        end
        S_RIK: begin
          state_r <= S_LIK;
        end
        S_LIK: begin
          dik_r   <= rd_data_a;
          state_r <= S_RD;
        end
        S_RD: begin
          state_r <= S_UPD;
        end
        S_UPD: begin
          if (improve) begin
            via_valid_r[dist_wr_addr] <= 1'b1;
          end
          // Advance j fastest, then i, then the pivot k.
          if (j_r == last_r) begin
            j_r <= '0;
            if (i_r == last_r) begin
              i_r <= '0;
              if (k_r == last_r) begin
                state_r <= S_POST;
              end else begin
                k_r     <= k_r + IDX_W'(1);
                state_r <= S_RIK;
              end
            end else begin
              i_r     <= i_r + IDX_W'(1);
              state_r <= S_RIK;
            end
          end else begin
            j_r     <= j_r + IDX_W'(1);
            state_r <= S_RD;
          end
        end
        S_POST: begin
          if (post_fire) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // Output register: take a finished result, or drop the one accepted.
      if (post_fire) begin
        out_valid_r <= 1'b1;
        out_dist_r  <= res_dist_r;
        out_via_r   <= res_via_r;
        out_has_r   <= res_has_r;
        out_done_r  <= res_done_r;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_done_r, out_has_r, out_via_r, out_dist_r};

  // A store write while idle only comes from an accepted load request.
  a_idle_write_is_load: assert property (@(posedge clk) disable iff (!rst_n)
    (dist_wr_en && state_r == S_IDLE) |->
      (in_acc && in_func == apsp_pkg::FUNC_LOAD && in_store))
    else $error("distance write while idle without a load request");

  // A compute request starts with every via entry cleared.
  a_compute_clears_via: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_func == apsp_pkg::FUNC_COMPUTE) |=> (via_valid_r == '0))
    else $error("via entries not cleared at compute start");

  // Loop counters stay within the vertices in use during a compute.
  a_counters_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RIK || state_r == S_LIK || state_r == S_RD || state_r == S_UPD) |->
      (i_r <= last_r && j_r <= last_r && k_r <= last_r))
    else $error("relaxation counter beyond vertex count");

  // A result without a via vertex carries a zero via field.
  a_no_via_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_has_r) |-> (out_via_r == '0))
    else $error("via field set without a via vertex");

endmodule

// ===== design/apsp_ram.sv =====
// ----------------------------------------------------------------------------
// apsp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module apsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sim/all_pairs_shortest_path_via_unit_test.sv =====
// ----------------------------------------------------------------------------
// all_pairs_shortest_path_via_unit_test: self-checking bench for the APSP unit
// Fills the distance store, then runs directed cases, vertex count extremes,
// a backpressure stretch and random graph phases (load, compute, read). Every
// accepted request is run through a local Floyd-Warshall predictor, and each
// result is compared field by field against the oldest awaited result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module all_pairs_shortest_path_via_unit_test;

  // Shared sizes and codes.
  localparam int MAX_VERTICES = apsp_pkg::MAX_VERTICES;
  localparam int VTX_W        = apsp_pkg::VTX_W;
  localparam int DIST_W       = apsp_pkg::DIST_W;
  localparam int VC_W         = apsp_pkg::VC_W;
  localparam logic [DIST_W-1:0] NO_EDGE  = apsp_pkg::NO_EDGE;
  localparam logic [VC_W-1:0]   VC_RESET = apsp_pkg::VC_RESET;

  typedef apsp_pkg::func_t func_t;

  localparam func_t FUNC_LOAD    = apsp_pkg::FUNC_LOAD;
  localparam func_t FUNC_COMPUTE = apsp_pkg::FUNC_COMPUTE;
  localparam func_t FUNC_READ    = apsp_pkg::FUNC_READ;
  localparam func_t FUNC_NONE    = apsp_pkg::FUNC_NONE;

  localparam int ITEM_TARGET  = 1950;
  localparam int STEADY_ITEMS = 250;
  localparam int LONG_HOLD    = 80;
  localparam int TAIL_CYCLES  = 12;
  localparam int TIMEOUT_NS   = 2_000_000;
  localparam int ENTRIES      = MAX_VERTICES * MAX_VERTICES;

  // One result as the block reports it.
  typedef struct packed {
    logic              done_res;
    logic              has_via;
    logic [VTX_W-1:0]  via_vertex;
    logic [DIST_W-1:0] distance;
  } path_result_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [4:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  // Local copy of the graph state and the vertex count register.
  logic [DIST_W-1:0] dist_model [ENTRIES];
  logic [VTX_W-1:0]  via_model  [ENTRIES];
  bit                via_set    [ENTRIES];
  logic [VC_W-1:0]   vcount_model;

  path_result_t awaited_results [$];
  int           error_count;
  int           sent_count;
  bit           steady_run;
  bit           long_hold_req;

  all_pairs_shortest_path_via_unit DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog for a hung run.
  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The vertex count in use, clamped to between one and the size of the store.
  function automatic int active_vertices(input logic [VC_W-1:0] v);
    if (v < 1) return 1;
    if (v > MAX_VERTICES) return MAX_VERTICES;
    return int'(v);
  endfunction

  // Floyd-Warshall over the active vertices with saturating sums.
  function automatic void relax_all_pairs();
    int n;
    logic [DIST_W:0] sum;
    n = active_vertices(vcount_model);
    for (int i = 0; i < n; i++) dist_model[i * MAX_VERTICES + i] = '0;
    foreach (via_set[e]) via_set[e] = 1'b0;
    for (int k = 0; k < n; k++) begin
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          sum = {1'b0, dist_model[i * MAX_VERTICES + k]} +
                {1'b0, dist_model[k * MAX_VERTICES + j]};
          if (sum > {1'b0, NO_EDGE}) sum = {1'b0, NO_EDGE};
          if (dist_model[i * MAX_VERTICES + j] > sum[DIST_W-1:0]) begin
            dist_model[i * MAX_VERTICES + j] = sum[DIST_W-1:0];
            via_model[i * MAX_VERTICES + j]  = VTX_W'(k);
            via_set[i * MAX_VERTICES + j]    = 1'b1;
          end
        end
      end
    end
  endfunction

  // Applies one request to the local state and returns the result it causes.
  function automatic path_result_t apply_request(input func_t f,
                                                 input logic [VTX_W-1:0] r,
                                                 input logic [VTX_W-1:0] c,
                                                 input logic [DIST_W-1:0] w);
    path_result_t res;
    int idx;
    res = '0;
    idx = int'(r) * MAX_VERTICES + int'(c);
    case (f)
      FUNC_LOAD: begin
        dist_model[idx] = (w > NO_EDGE) ? NO_EDGE : w;
        res.done_res = 1'b1;
      end
      FUNC_COMPUTE: begin
        relax_all_pairs();
        res.done_res = 1'b1;
      end
      FUNC_READ: begin
        res.distance = dist_model[idx];
        if (via_set[idx]) begin
          res.via_vertex = via_model[idx];
          res.has_via    = 1'b1;
        end
        res.done_res = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Scoreboard: tracks config writes, checks results, predicts requests.
  always @(posedge clk) begin : scoreboard
    path_result_t want;
    if (!rst_n) begin
      error_count  = 0;
      vcount_model = VC_RESET;
      foreach (via_set[e]) begin
        dist_model[e] = '0;
        via_model[e]  = '0;
        via_set[e]    = 1'b0;
      end
    end else begin
      if (cfg_wr_en) vcount_model = cfg_wr_data;
      if (out_tvalid && out_tready) begin
        if (awaited_results.size() == 0) begin
          $error("result with no request awaiting it: out_tdata %h", out_tdata);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (out_tdata[16:0] !== want.distance) begin
            $error("distance: expected %0d, actual %0d", want.distance, out_tdata[16:0]);
            error_count++;
          end
          if (out_tdata[20:17] !== want.via_vertex) begin
            $error("via_vertex: expected %0d, actual %0d", want.via_vertex,
                   out_tdata[20:17]);
            error_count++;
          end
          if (out_tdata[21] !== want.has_via) begin
            $error("has_via: expected %0d, actual %0d", want.has_via, out_tdata[21]);
            error_count++;
          end
          if (out_tdata[22] !== want.done_res) begin
            $error("done_res: expected %0d, actual %0d", want.done_res, out_tdata[22]);
            error_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        want = apply_request(func_t'(in_tuser), in_tdata[3:0], in_tdata[7:4],
                             in_tdata[24:8]);
        awaited_results = {awaited_results, want};
      end
    end
  end

  // Result sink: random stalls, plus one long hold when a test asks for it.
  initial begin : result_sink
    bit hold_taken;
    hold_taken = 1'b0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!steady_run && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Offers one request and returns at the edge where it is accepted.
  task automatic send_request(input func_t f, input logic [VTX_W-1:0] r,
                              input logic [VTX_W-1:0] c, input logic [DIST_W-1:0] w);
    if (!steady_run && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= f;
    in_tdata  <= {7'd0, w, c, r};
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Stops offering requests until every awaited result has come back.
  task automatic drain_requests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes the vertex count register; only called while the block is idle.
  task automatic write_vertex_count(input logic [VC_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Weight mix: mostly short edges, some no-edge, some large or over range.
  function automatic logic [DIST_W-1:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return NO_EDGE;
      1:       return DIST_W'($urandom_range(0, 131071));
      2:       return DIST_W'($urandom_range(30000, 99999));
      default: return DIST_W'($urandom_range(0, 40));
    endcase
  endfunction

  // Off-pattern request: unused code, stray load or read, compute if n <= 8.
  task automatic send_noise(input int n);
    case ($urandom_range(0, 3))
      0: send_request(FUNC_NONE, VTX_W'($urandom_range(0, 15)),
                      VTX_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 131071)));
      1: send_request(FUNC_LOAD, VTX_W'($urandom_range(0, 15)),
                      VTX_W'($urandom_range(0, 15)), pick_weight());
      2: send_request(FUNC_READ, VTX_W'($urandom_range(0, 15)),
                      VTX_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 131071)));
      default: begin
        if (n <= 8) begin
          send_request(FUNC_COMPUTE, VTX_W'($urandom_range(0, 15)),
                       VTX_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 131071)));
        end else begin
          send_request(FUNC_READ, VTX_W'($urandom_range(0, 15)),
                       VTX_W'($urandom_range(0, 15)), '0);
        end
      end
    endcase
  endtask

  // Loads every entry of the store so no later read or compute sees an
  // unwritten distance.
  task automatic test_fill_store();
    for (int r = 0; r < MAX_VERTICES; r++) begin
      for (int c = 0; c < MAX_VERTICES; c++) begin
        send_request(FUNC_LOAD, VTX_W'(r), VTX_W'(c), pick_weight());
      end
    end
    drain_requests();
  endtask

  // Hand-built chain on four vertices: via recording, saturated loads,
  // saturated sums, reads outside the active range and the unused code.
  task automatic test_directed_cases();
    write_vertex_count(VC_W'(4));
    send_request(FUNC_LOAD, 4'd0, 4'd1, 17'd3);
    send_request(FUNC_LOAD, 4'd1, 4'd2, 17'd4);
    send_request(FUNC_LOAD, 4'd2, 4'd3, 17'd5);
    send_request(FUNC_LOAD, 4'd0, 4'd2, 17'd20);
    send_request(FUNC_LOAD, 4'd0, 4'd3, NO_EDGE);
    send_request(FUNC_LOAD, 4'd1, 4'd3, 17'h1FFFF);
    send_request(FUNC_LOAD, 4'd1, 4'd0, 17'd100000);
    send_request(FUNC_LOAD, 4'd3, 4'd0, 17'd0);
    send_request(FUNC_LOAD, 4'd15, 4'd15, 17'd0);
    send_request(FUNC_COMPUTE, 4'd0, 4'd0, 17'd0);
    send_request(FUNC_READ, 4'd0, 4'd3, 17'd0);
    send_request(FUNC_READ, 4'd0, 4'd2, 17'd0);
    send_request(FUNC_READ, 4'd1, 4'd0, 17'd0);
    send_request(FUNC_READ, 4'd0, 4'd0, 17'd0);
    send_request(FUNC_READ, 4'd15, 4'd15, 17'd0);
    send_request(FUNC_READ, 4'd15, 4'd0, 17'd0);
    send_request(FUNC_NONE, 4'd15, 4'd15, 17'h1FFFF);
    // Two long hops whose sum saturates must not replace a no-edge entry.
    send_request(FUNC_LOAD, 4'd0, 4'd1, 17'd60000);
    send_request(FUNC_LOAD, 4'd1, 4'd2, 17'd60000);
    send_request(FUNC_LOAD, 4'd0, 4'd2, NO_EDGE);
    send_request(FUNC_LOAD, 4'd3, 4'd2, NO_EDGE);
    send_request(FUNC_COMPUTE, 4'd15, 4'd15, 17'h1FFFF);
    send_request(FUNC_READ, 4'd0, 4'd2, 17'd0);
    send_request(FUNC_READ, 4'd0, 4'd15, 17'd0);
    drain_requests();
  endtask

  // Register extremes, including counts that clamp to one and to the store.
  task automatic test_vertex_count_extremes();
    logic [VC_W-1:0] settings [4];
    int n;
    settings = '{VC_W'(0), VC_W'(1), VC_W'(31), VC_W'(16)};
    foreach (settings[s]) begin
      write_vertex_count(settings[s]);
      n = active_vertices(settings[s]);
      repeat (3) send_request(FUNC_LOAD, VTX_W'($urandom_range(0, n - 1)),
                              VTX_W'($urandom_range(0, n - 1)), pick_weight());
      send_request(FUNC_COMPUTE, 4'd0, 4'd0, 17'd0);
      send_request(FUNC_READ, 4'd0, 4'd0, 17'd0);
      send_request(FUNC_READ, VTX_W'(n - 1), 4'd0, 17'd0);
      send_request(FUNC_READ, 4'd15, 4'd15, 17'd0);
      send_request(FUNC_READ, VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)),
                   17'd0);
      drain_requests();
    end
  endtask

  // The sink holds off for a long stretch while requests keep coming, so the
  // block fills up and lowers in_tready.
  task automatic test_backpressure();
    write_vertex_count(VC_W'(3));
    long_hold_req = 1'b1;
    repeat (40) begin
      send_request($urandom_range(0, 1) ? FUNC_READ : FUNC_LOAD,
                   VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)),
                   pick_weight());
    end
    drain_requests();
  endtask

  // Random graph phases: a vertex count, edge loads, a compute, then reads,
  // with some stray requests mixed in.
  task automatic test_random_graphs();
    logic [VC_W-1:0] vc;
    int n;
    while (sent_count < ITEM_TARGET) begin
      if (sent_count >= ITEM_TARGET - STEADY_ITEMS) steady_run = 1'b1;
      case ($urandom_range(0, 15))
        0:       vc = VC_W'($urandom_range(17, 31));
        1:       vc = VC_W'(MAX_VERTICES);
        2:       vc = '0;
        3:       vc = VC_W'(1);
        default: vc = VC_W'($urandom_range(2, 6));
      endcase
      write_vertex_count(vc);
      n = active_vertices(vc);
      repeat ($urandom_range(1, 2 * n)) begin
        if ($urandom_range(0, 7) == 0) send_noise(n);
        else send_request(FUNC_LOAD, VTX_W'($urandom_range(0, n - 1)),
                          VTX_W'($urandom_range(0, n - 1)), pick_weight());
      end
      send_request(FUNC_COMPUTE, VTX_W'($urandom_range(0, 15)),
                   VTX_W'($urandom_range(0, 15)), DIST_W'($urandom_range(0, 131071)));
      repeat ($urandom_range(4, 20)) begin
        if ($urandom_range(0, 7) == 0) send_noise(n);
        else send_request(FUNC_READ, VTX_W'($urandom_range(0, n - 1)),
                          VTX_W'($urandom_range(0, n - 1)),
                          DIST_W'($urandom_range(0, 131071)));
      end
      drain_requests();
    end
  endtask

  // Test sequence.
  initial begin
    sent_count    = 0;
    steady_run    = 1'b0;
    long_hold_req = 1'b0;
    rst_n       <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    in_tvalid   <= 1'b0;
    in_tdata    <= '0;
    in_tuser    <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_fill_store();
    test_directed_cases();
    test_vertex_count_extremes();
    test_backpressure();
    test_random_graphs();

    drain_requests();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
